/* rtl/kvs_pkg.sv */
// ----------------------------------------------------------------------------
// kvs_pkg
// Shared constants, sizes and state types of the key/value store engine.
// ----------------------------------------------------------------------------
package kvs_pkg;

  // store geometry
  localparam int ENTRIES       = 256;
  localparam int KEY_BYTES     = 64;
  localparam int CONTENT_BYTES = 32;

  // request kinds
  localparam logic [7:0] KIND_GET = 8'h01;
  localparam logic [7:0] KIND_PUT = 8'h02;

  // derived sizes, stores are kept as 64-bit words of eight bytes
  localparam int IDX_W      = $clog2(ENTRIES);
  localparam int CNT_W      = $clog2(ENTRIES + 1);
  localparam int KEY_WORDS  = KEY_BYTES / 8;
  localparam int KW_W       = $clog2(KEY_WORDS);
  localparam int CONT_WORDS = CONTENT_BYTES / 8;
  localparam int CW_W       = $clog2(CONT_WORDS);
  localparam int LEN_W      = $clog2(CONTENT_BYTES + 1);
  localparam int POS_W      = $clog2(KEY_BYTES + 1);
  localparam int RESP_W     = $clog2(CONTENT_BYTES + 3);

  typedef enum logic [2:0] {
    PH_IDLE,
    PH_KLEN,
    PH_KEY,
    PH_DHI,
    PH_DLO,
    PH_DATA
  } parse_phase_t;

  typedef enum logic [2:0] {
    EX_IDLE,
    EX_SEARCH,
    EX_DECIDE,
    EX_KEYWR,
    EX_CONTWR,
    EX_LENRD,
    EX_RESP,
    EX_CRD
  } exec_state_t;

endpackage

/* rtl/kvs_ram.sv */
// ----------------------------------------------------------------------------
// kvs_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
module kvs_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // read port, data holds until the next read
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

/* rtl/key_value_store_engine.sv */
// ----------------------------------------------------------------------------
// key_value_store_engine
// Byte-serial request parser over a key/value store searched linearly.
// ----------------------------------------------------------------------------
// Request bytes are taken one per cycle while the engine is parsing. When a
// GET or PUT frame completes, in_ready drops until the answer has been queued:
// the key search reads the key memory one 64-bit word a cycle, entry after
// entry, a PUT that appends adds 8 key-word writes, every PUT that stores
// adds 4 content-word writes, and the answer goes out at one byte a cycle
// while out_ready allows, with each content word of a GET hit read before its
// bytes. Stores need no clearing after reset.
module key_value_store_engine (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic       frame_start,
  input  logic [7:0] data_byte,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [7:0] resp_byte,
  output logic       resp_last
);
  import kvs_pkg::*;

  parse_phase_t phase, phase_next;
  exec_state_t  state, state_next;

  logic [7:0]       kind;
  logic [POS_W-1:0] klen;
  logic [7:0]       dhi;
  logic [LEN_W-1:0] dlen;
  logic [POS_W-1:0] pos;
  logic             seen_zero;
  logic [63:0]      probe [KEY_WORDS];
  logic [63:0]      dbuf  [CONT_WORDS];

  logic             in_acc;
  logic             go;
  logic             go_exec;
  logic [POS_W-1:0] pos_inc;
  logic [15:0]      len16;

  // search and write-back control
  logic [IDX_W-1:0]  se, ce, widx;
  logic [KW_W-1:0]   sw, cw;
  logic              iss, cmp_valid, acc, hit, status;
  logic [CNT_W-1:0]  entry_count;
  logic [CNT_W-1:0]  cnt_m1;
  logic [RESP_W-1:0] r, r_inc, rk, rk_inc, resp_total;
  logic              eq, acc_n, last_w, last_e, found, exhausted;
  logic              room, is_put, resp_end;
  logic [7:0]        resp_val;

  logic [63:0]      key_rdata, cont_rdata;
  logic [LEN_W-1:0] len_rdata;

  assign in_ready = (state == EX_IDLE);
  assign in_acc   = in_valid && in_ready;
  assign pos_inc  = pos + 1'b1;
  assign len16    = {dhi, data_byte};

  // parse phase next state
  always_comb begin
    phase_next = phase;
    go         = 1'b0;
    if (in_acc) begin
      if (frame_start) begin
        phase_next = PH_KLEN;
      end else begin
        case (phase)
          PH_KLEN: begin
            if (data_byte == 8'd0 || data_byte > KEY_BYTES) phase_next = PH_IDLE;
            else phase_next = PH_KEY;
          end
          PH_KEY: begin
            if (pos_inc >= klen) phase_next = PH_DHI;
          end
          PH_DHI: phase_next = PH_DLO;
          PH_DLO: begin
            if (len16 == 16'd0) begin
              phase_next = PH_IDLE;
              go         = 1'b1;
            end else if (len16 > CONTENT_BYTES) begin
              phase_next = PH_IDLE;
            end else begin
              phase_next = PH_DATA;
            end
          end
          PH_DATA: begin
            if (pos_inc >= dlen) begin
              phase_next = PH_IDLE;
              go         = 1'b1;
            end
          end
          default: phase_next = PH_IDLE;
        endcase
      end
    end
  end

  assign go_exec = go && (kind == KIND_PUT || kind == KIND_GET);

  // parse registers
  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= PH_IDLE;
    end else begin
      phase <= phase_next;
    end
  end

  // frame buffers
  always_ff @(posedge clk) begin
    if (in_acc) begin
      if (frame_start) begin
        kind      <= data_byte;
        pos       <= '0;
        seen_zero <= 1'b0;
        for (int i = 0; i < KEY_WORDS; i++) probe[i] <= '0;
      end else begin
        case (phase)
          PH_KLEN: begin
            klen <= data_byte[POS_W-1:0];
            pos  <= '0;
          end
          PH_KEY: begin
            // bytes from the first zero on are stored as zero
            probe[pos[KW_W+2:3]][8*pos[2:0] +: 8] <=
              (seen_zero || data_byte == 8'd0) ? 8'd0 : data_byte;
            if (data_byte == 8'd0) seen_zero <= 1'b1;
            pos <= pos_inc;
          end
          PH_DHI: dhi <= data_byte;
          PH_DLO: begin
            dlen <= data_byte[LEN_W-1:0];
            pos  <= '0;
          end
          PH_DATA: begin
            dbuf[pos[CW_W+2:3]][8*pos[2:0] +: 8] <= data_byte;
            pos <= pos_inc;
          end
          default: pos <= pos;
        endcase
      end
    end
  end

  // search compare, one key word per cycle
  assign cnt_m1    = entry_count - 1'b1;
  assign eq        = (key_rdata == probe[cw]);
  assign acc_n     = ((cw == '0) ? 1'b1 : acc) && eq;
  assign last_w    = (cw == KW_W'(KEY_WORDS - 1));
  assign last_e    = (ce == cnt_m1[IDX_W-1:0]);
  assign found     = cmp_valid && last_w && acc_n;
  assign exhausted = cmp_valid && last_w && !acc_n && last_e;

  // response byte selection
  assign is_put     = (kind == KIND_PUT);
  assign room       = !out_valid || out_ready;
  assign r_inc      = r + 1'b1;
  assign rk         = r - RESP_W'(2);
  assign rk_inc     = r_inc - RESP_W'(2);
  assign resp_total = is_put ? RESP_W'(3) :
                      (hit ? RESP_W'(2) + RESP_W'(len_rdata) : RESP_W'(2));
  assign resp_end   = (r_inc == resp_total);

  always_comb begin
    if (r == '0) resp_val = 8'd0;
    else if (r == RESP_W'(1)) resp_val = is_put ? 8'd1 : (hit ? 8'(len_rdata) : 8'd0);
    else if (is_put) resp_val = {7'd0, status};
    else resp_val = cont_rdata[8*rk[2:0] +: 8];
  end

  // execution next state
  always_comb begin
    state_next = state;
    case (state)
      EX_IDLE: begin
        if (go_exec) state_next = (entry_count == '0) ? EX_DECIDE : EX_SEARCH;
      end
      EX_SEARCH: begin
        if (found || exhausted) state_next = EX_DECIDE;
      end
      EX_DECIDE: begin
        if (is_put) begin
          if (hit) state_next = EX_CONTWR;
          else if (entry_count < ENTRIES) state_next = EX_KEYWR;
          else state_next = EX_RESP;
        end else begin
          state_next = hit ? EX_LENRD : EX_RESP;
        end
      end
      EX_KEYWR: begin
        if (sw == KW_W'(KEY_WORDS - 1)) state_next = EX_CONTWR;
      end
      EX_CONTWR: begin
        if (sw[CW_W-1:0] == CW_W'(CONT_WORDS - 1)) state_next = EX_RESP;
      end
      EX_LENRD: state_next = EX_RESP;
      EX_RESP: begin
        if (room) begin
          if (resp_end) state_next = EX_IDLE;
          else if (!is_put && hit && r_inc >= RESP_W'(2) && rk_inc[2:0] == 3'd0)
            state_next = EX_CRD;
        end
      end
      EX_CRD: state_next = EX_RESP;
      default: state_next = EX_IDLE;
    endcase
  end

  // execution control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= EX_IDLE;
      entry_count <= '0;
      cmp_valid   <= 1'b0;
      iss         <= 1'b0;
    end else begin
      state <= state_next;
      case (state)
        EX_IDLE: begin
          cmp_valid <= 1'b0;
          iss       <= (entry_count != '0);
          if (entry_count == '0 && go_exec) entry_count <= entry_count;
        end
        EX_SEARCH: begin
          cmp_valid <= iss && !(found || exhausted);
          if (iss && sw == KW_W'(KEY_WORDS - 1) && se == cnt_m1[IDX_W-1:0]) iss <= 1'b0;
        end
        EX_DECIDE: begin
          if (is_put && !hit && entry_count < ENTRIES) entry_count <= entry_count + 1'b1;
        end
        default: cmp_valid <= 1'b0;
      endcase
    end
  end

  // execution datapath registers
  always_ff @(posedge clk) begin
    case (state)
      EX_IDLE: begin
        hit <= 1'b0;
        se  <= '0;
        sw  <= '0;
      end
      EX_SEARCH: begin
        if (iss) begin
          sw <= sw + 1'b1;
          if (sw == KW_W'(KEY_WORDS - 1)) se <= se + 1'b1;
        end
        ce <= se;
        cw <= sw;
        if (cmp_valid) acc <= acc_n;
        if (found) begin
          hit  <= 1'b1;
          widx <= ce;
        end
      end
      EX_DECIDE: begin
        sw     <= '0;
        r      <= '0;
        status <= hit || (entry_count < ENTRIES);
        if (is_put && !hit) widx <= entry_count[IDX_W-1:0];
      end
      EX_KEYWR: sw <= sw + 1'b1;
      EX_CONTWR: begin
        sw <= (sw[CW_W-1:0] == CW_W'(CONT_WORDS - 1)) ? '0 : sw + 1'b1;
        r  <= '0;
      end
      EX_RESP: begin
        if (room && !resp_end) r <= r_inc;
      end
      default: r <= r;
    endcase
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (state == EX_RESP && room) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == EX_RESP && room) begin
      resp_byte <= resp_val;
      resp_last <= resp_end;
    end
  end

  // key memory: entry index and word within the key
  kvs_ram #(.WIDTH(64), .DEPTH(ENTRIES * KEY_WORDS)) u_key_ram (
    .clk   (clk),
    .we    (state == EX_KEYWR),
    .waddr ({widx, sw}),
    .wdata (probe[sw]),
    .re    (state == EX_SEARCH && iss),
    .raddr ({se, sw}),
    .rdata (key_rdata)
  );

  // content memory
  kvs_ram #(.WIDTH(64), .DEPTH(ENTRIES * CONT_WORDS)) u_cont_ram (
    .clk   (clk),
    .we    (state == EX_CONTWR),
    .waddr ({widx, sw[CW_W-1:0]}),
    .wdata (dbuf[sw[CW_W-1:0]]),
    .re    (state == EX_CRD),
    .raddr ({widx, rk[CW_W+2:3]}),
    .rdata (cont_rdata)
  );

  // content length memory
  kvs_ram #(.WIDTH(LEN_W), .DEPTH(ENTRIES)) u_len_ram (
    .clk   (clk),
    .we    (state == EX_CONTWR && sw[CW_W-1:0] == CW_W'(CONT_WORDS - 1)),
    .waddr (widx),
    .wdata (dlen),
    .re    (state == EX_LENRD),
    .raddr (widx),
    .rdata (len_rdata)
  );

  // checks
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    entry_count <= CNT_W'(ENTRIES))
    else $error("entry count above capacity");

  a_keywr_count: assert property (@(posedge clk) disable iff (rst)
    state == EX_KEYWR |-> entry_count != '0)
    else $error("key written with no entry allocated");

  a_resp_bound: assert property (@(posedge clk) disable iff (rst)
    state == EX_RESP |-> r < RESP_W'(CONTENT_BYTES + 2))
    else $error("response index out of range");

endmodule
